// ===== rtl/obsc_pkg.sv =====
`default_nettype none

package obsc_pkg;

  localparam int TAG_LEN    = 5;
  localparam int MIN_LENGTH = 6;
  localparam int DEC_BASE   = 10;

  localparam logic [7:0] ZERO_BYTE   = 8'h00;
  localparam logic [7:0] DIGIT_FIRST = 8'h30;
  localparam logic [7:0] DIGIT_LAST  = 8'h39;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } parse_phase_t;

  typedef enum logic [1:0] {
    DG_BEFORE = 2'd0,
    DG_IN     = 2'd1,
    DG_DONE   = 2'd2
  } digit_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        object_valid;
    logic [31:0] payload_size;
    logic [31:0] payload_offset;
    logic        size_overflow;
  } result_t;

  // expected "blob " tag
  function automatic logic [7:0] tag_byte(input logic [2:0] pos);
    logic [7:0] val;
    case (pos)
      3'd0: val = 8'h62;
      3'd1: val = 8'h6C;
      3'd2: val = 8'h6F;
      3'd3: val = 8'h62;
      3'd4: val = 8'h20;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/object_header_stream_checker_core.sv =====
// channel   direction  handshake                   payload
// item      in         item_valid / item_ready     obsc_pkg::item_t
// result    out        result_valid / result_ready obsc_pkg::result_t
//
// one byte per cycle while the result register can take each last byte: input register, then parse and result register
// a last byte's result enters the result register when that byte leaves the input register and the slot is free
// header state updates through a times-ten add and compare
// rst is synchronous and clears handshake and header state
// only a last byte waits on a full result register; other bytes keep flowing
`default_nettype none

module object_header_stream_checker_core #(
  parameter int LENGTH_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire obsc_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output obsc_pkg::result_t      result
);

  logic              q_valid;
  obsc_pkg::item_t   q_item;
  logic              take;
  logic              res_load;
  logic              slot_free;
  obsc_pkg::result_t res;

  obsc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (take),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  obsc_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .slot_free (slot_free),
    .take      (take),
    .res_load  (res_load),
    .res       (res)
  );

  obsc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res_load     (res_load),
    .res          (res),
    .slot_free    (slot_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== rtl/obsc_in_stage.sv =====
`default_nettype none

module obsc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire obsc_pkg::item_t item,
  input  wire logic           take,
  output logic                q_valid,
  output obsc_pkg::item_t     q_item
);

  logic q_valid_next;
  logic accept;

  assign item_ready = !q_valid || take;
  assign accept     = item_valid && item_ready;

  always_comb begin
    if (accept) begin
      q_valid_next = 1'b1;
    end else if (take) begin
      q_valid_next = 1'b0;
    end else begin
      q_valid_next = q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item <= item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/obsc_parser.sv =====
`default_nettype none

module obsc_parser #(
  parameter int LENGTH_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire obsc_pkg::item_t  q_item,
  input  wire logic             slot_free,
  output logic                  take,
  output logic                  res_load,
  output obsc_pkg::result_t     res
);

  localparam int W = LENGTH_WIDTH;
  localparam logic [W-1:0] MAXV = '1;

  logic [W-1:0]           byte_count, byte_count_next;
  logic                   tag_match, tag_match_next;
  obsc_pkg::parse_phase_t parse_phase, parse_phase_next;
  obsc_pkg::digit_phase_t digit_phase, digit_phase_next;
  logic [W-1:0]           size_acc, size_acc_next;
  logic [W-1:0]           header_end, header_end_next;
  logic                   overflow_seen, overflow_seen_next;

  logic [7:0]   b;
  logic [W-1:0] idx;
  logic [3:0]   digit;
  logic [W+3:0] scaled;
  logic [W-1:0] length;
  logic         len_ok;
  logic         zero_seen;
  logic         valid;
  logic [63:0]  size_ext;
  logic [63:0]  offset_ext;

  assign take     = q_valid && (!q_item.last_byte || slot_free);
  assign res_load = take && q_item.last_byte;

  assign b      = q_item.data_byte;
  assign idx    = byte_count;
  assign digit  = 4'(b - obsc_pkg::DIGIT_FIRST);
  assign scaled = ({4'b0, size_acc} << 3) + ({4'b0, size_acc} << 1) + (W+4)'(digit);

  always_comb begin
    tag_match_next     = tag_match;
    parse_phase_next   = parse_phase;
    digit_phase_next   = digit_phase;
    size_acc_next      = size_acc;
    header_end_next    = header_end;
    overflow_seen_next = overflow_seen;

    case (parse_phase)
      obsc_pkg::PH_TAG: begin
        if (idx < W'(obsc_pkg::TAG_LEN)) begin
          if (b != obsc_pkg::tag_byte(idx[2:0])) begin
            tag_match_next = 1'b0;
          end
          if (idx == W'(obsc_pkg::TAG_LEN - 1)) begin
            parse_phase_next = obsc_pkg::PH_HEADER;
          end
        end
      end
      obsc_pkg::PH_HEADER: begin
        if (b == obsc_pkg::ZERO_BYTE) begin
          header_end_next  = idx + W'(1);
          parse_phase_next = obsc_pkg::PH_PAYLOAD;
          digit_phase_next = obsc_pkg::DG_DONE;
        end else if (b inside {[obsc_pkg::DIGIT_FIRST:obsc_pkg::DIGIT_LAST]}) begin
          if (digit_phase != obsc_pkg::DG_DONE) begin
            if (scaled[W+3:W] != 4'd0) begin
              size_acc_next      = MAXV;
              overflow_seen_next = 1'b1;
            end else begin
              size_acc_next = scaled[W-1:0];
            end
            digit_phase_next = obsc_pkg::DG_IN;
          end
        end else if (digit_phase == obsc_pkg::DG_IN) begin
          digit_phase_next = obsc_pkg::DG_DONE;
        end
      end
      default: begin
      end
    endcase

    byte_count_next = (byte_count != MAXV) ? byte_count + W'(1) : byte_count;

    len_ok    = idx != MAXV;
    length    = idx + W'(1);
    zero_seen = parse_phase_next == obsc_pkg::PH_PAYLOAD;
    valid     = len_ok && (length >= W'(obsc_pkg::MIN_LENGTH)) && tag_match_next &&
                zero_seen && !overflow_seen_next && (header_end_next <= length) &&
                ((length - header_end_next) == size_acc_next);

    size_ext   = 64'(size_acc_next);
    offset_ext = zero_seen ? 64'(header_end_next) : 64'd0;

    res.object_valid   = valid;
    res.payload_size   = size_ext[31:0];
    res.payload_offset = offset_ext[31:0];
    res.size_overflow  = overflow_seen_next;

    // end of object: back to the start state
    if (q_item.last_byte) begin
      byte_count_next    = '0;
      tag_match_next     = 1'b1;
      parse_phase_next   = obsc_pkg::PH_TAG;
      digit_phase_next   = obsc_pkg::DG_BEFORE;
      size_acc_next      = '0;
      header_end_next    = '0;
      overflow_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      tag_match     <= 1'b1;
      parse_phase   <= obsc_pkg::PH_TAG;
      digit_phase   <= obsc_pkg::DG_BEFORE;
      size_acc      <= '0;
      header_end    <= '0;
      overflow_seen <= 1'b0;
    end else if (take) begin
      byte_count    <= byte_count_next;
      tag_match     <= tag_match_next;
      parse_phase   <= parse_phase_next;
      digit_phase   <= digit_phase_next;
      size_acc      <= size_acc_next;
      header_end    <= header_end_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (byte_count == '0) && (parse_phase == obsc_pkg::PH_TAG))
    else $error("state not cleared after last byte");

  a_end_phase: assert property (@(posedge clk) disable iff (rst)
    (header_end != '0) |-> (parse_phase == obsc_pkg::PH_PAYLOAD))
    else $error("header end recorded outside payload phase");

  a_digits_done: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == obsc_pkg::PH_PAYLOAD) |-> (digit_phase == obsc_pkg::DG_DONE))
    else $error("digit run still open in payload");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (size_acc == MAXV))
    else $error("size not saturated after overflow");

endmodule

`default_nettype wire

// ===== rtl/obsc_out_stage.sv =====
`default_nettype none

module obsc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_load,
  input  wire obsc_pkg::result_t res,
  output logic                   slot_free,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output obsc_pkg::result_t      result
);

  logic result_valid_next;

  assign slot_free = !result_valid || result_ready;

  always_comb begin
    if (res_load) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire
